@@ design/hpt_pkg.sv @@
// heard peer table package: sizes, reset values and the token and write-back structs
// shared by the slot cells and the top level; no dependencies
package hpt_pkg;

  localparam int unsigned PeerSlotsDef = 24;
  localparam int unsigned PeerSlotsMax = 64;
  localparam int unsigned SlotIdxW     = $clog2(PeerSlotsMax);
  localparam int unsigned SlotCntW     = $clog2(PeerSlotsMax + 1);
  localparam int unsigned ActiveW      = 5;
  localparam logic [ActiveW-1:0] CountMax    = 5'd31;
  localparam logic [31:0]        MaxAgeReset = 32'd120000;

  // one sighting walking down the cell row
  typedef struct packed {
    logic                valid;
    logic                mode;
    logic [7:0]          group_id;
    logic [7:0]          node_addr;
    logic [31:0]         now_ms;
    logic                matched;
    logic                vic_set;
    logic                vic_used;
    logic [SlotIdxW-1:0] vic_idx;
    logic [31:0]         vic_last;
    logic                vic_act;
    logic [SlotCntW-1:0] count;
  } hpt_tok_t;

  // write-back broadcast to the cells
  typedef struct packed {
    logic                en;
    logic [SlotIdxW-1:0] idx;
    logic [7:0]          group_id;
    logic [7:0]          node_addr;
    logic [31:0]         now_ms;
  } hpt_wr_t;

endpackage

@@ design/hpt_if.sv @@
// valid/ready channels of the heard peer table: sighting input and count output
// no dependencies
interface hpt_sight_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  group_id;
  logic [7:0]  node_addr;
  logic [31:0] now_ms;

  modport source(output valid, output mode, output group_id, output node_addr,
                 output now_ms, input ready);
  modport sink(input valid, input mode, input group_id, input node_addr,
               input now_ms, output ready);
endinterface

interface hpt_count_if;
  logic       valid;
  logic       ready;
  logic [4:0] active_peers;

  modport source(output valid, output active_peers, input ready);
  modport sink(input valid, input active_peers, output ready);
endinterface

@@ design/heard_peer_table_unit.sv @@
// heard peer table top level: row of slot cells, write-back, result and output registers
// depends on hpt_pkg, hpt_if and hpt_cell
//
//   channel   dir   handshake       payload
//   sight_i   in    valid / ready   mode, group_id, node_addr, now_ms
//   count_o   out   valid / ready   active_peers
//   cfg       in    cfg_we_i        cfg_wdata_i -> max_age_ms
//
// a transaction walks the cell row one slot per cycle, then enters the result register
// and, once the output register is empty or being taken, the output register
// one transaction in the row at a time; the next is taken once the row has drained and
// the result register is free, so one result may wait at the output meanwhile
// reset clears all used bits at once and loads max_age_ms with 120000
module heard_peer_table_unit #(
  parameter int unsigned PEER_SLOTS = hpt_pkg::PeerSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  hpt_sight_if.sink          sight_i,
  hpt_count_if.source        count_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);
  import hpt_pkg::*;

  hpt_tok_t                tok [PEER_SLOTS+1];
  hpt_tok_t                tail;
  hpt_wr_t                 wr;
  logic [PEER_SLOTS-1:0]   chain_v;

  logic [31:0]             max_age_q;
  logic                    busy_q, busy_d;
  logic                    res_valid_q, res_valid_d;
  logic [ActiveW-1:0]      res_cnt_q;
  logic                    out_valid_q, out_valid_d;
  logic [ActiveW-1:0]      out_cnt_q;

  logic                    in_fire;
  logic                    move;
  logic [7:0]              total;
  logic [ActiveW-1:0]      sat_cnt;

  assign sight_i.ready = !busy_q && !res_valid_q;
  assign in_fire       = sight_i.valid && sight_i.ready;

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = in_fire;
    tok[0].mode      = sight_i.mode;
    tok[0].group_id  = sight_i.group_id;
    tok[0].node_addr = sight_i.node_addr;
    tok[0].now_ms    = sight_i.now_ms;
  end

  for (genvar k = 0; k < PEER_SLOTS; k++) begin : g_cell
    hpt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (SlotIdxW'(k)),
      .max_age_i  (max_age_q),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1]),
      .wr_i       (wr)
    );
    assign chain_v[k] = tok[k+1].valid;
  end

  assign tail = tok[PEER_SLOTS];

  always_comb begin
    wr.en        = tail.valid && !tail.mode;
    wr.idx       = tail.vic_idx;
    wr.group_id  = tail.group_id;
    wr.node_addr = tail.node_addr;
    wr.now_ms    = tail.now_ms;
  end

  // the written entry has age zero, so it always counts; drop the old victim's share
  always_comb begin
    total = 8'(tail.count);
    if (!tail.mode && !tail.vic_act) begin
      total = 8'(tail.count) + 8'd1;
    end
    sat_cnt = (total > 8'(CountMax)) ? CountMax : total[ActiveW-1:0];
  end

  assign move = res_valid_q && (!out_valid_q || count_o.ready);

  always_comb begin
    busy_d = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (tail.valid) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (tail.valid) begin
      res_valid_d = 1'b1;
    end else if (move) begin
      res_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (count_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      max_age_q   <= MaxAgeReset;
    end else begin
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid) begin
      res_cnt_q <= sat_cnt;
    end
    if (move) begin
      out_cnt_q <= res_cnt_q;
    end
  end

  assign count_o.valid        = out_valid_q;
  assign count_o.active_peers = out_cnt_q;

  a_one_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_v))
    else $error("more than one transaction in the cell row");

  a_busy_has_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (|chain_v))
    else $error("busy without a transaction in the cell row");

  a_token_has_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|chain_v) |-> busy_q)
    else $error("transaction in the cell row while not busy");

  a_res_free_on_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> !res_valid_q)
    else $error("result register overrun");

endmodule

@@ design/hpt_cell.sv @@
// one slot of the heard peer table: holds an entry, matches, tracks the victim
// and counts active entries for the passing token; depends on hpt_pkg
module hpt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hpt_pkg::SlotIdxW-1:0]  slot_idx_i,
  input  logic [31:0]                   max_age_i,
  input  hpt_pkg::hpt_tok_t             tok_i,
  output hpt_pkg::hpt_tok_t             tok_o,
  input  hpt_pkg::hpt_wr_t              wr_i
);
  import hpt_pkg::*;

  logic        used_q;
  logic [7:0]  group_q;
  logic [7:0]  addr_q;
  logic [31:0] last_q;

  logic [31:0] age;
  logic [31:0] diff;
  logic        act;
  logic        hit;
  logic        older;
  logic        wr_here;
  hpt_tok_t    tok_d;
  hpt_tok_t    tok_q;

  assign age     = tok_i.now_ms - last_q;
  assign diff    = last_q - tok_i.vic_last;
  assign act     = used_q && (age <= max_age_i);
  assign hit     = used_q && (group_q == tok_i.group_id) && (addr_q == tok_i.node_addr);
  assign older   = diff[31];
  assign wr_here = wr_i.en && (wr_i.idx == slot_idx_i);

  always_comb begin
    tok_d       = tok_i;
    tok_d.count = tok_i.count + SlotCntW'(act);
    if (!tok_i.matched) begin
      tok_d.vic_set = 1'b1;
      if (hit) begin
        tok_d.matched = 1'b1;
        tok_d.vic_idx = slot_idx_i;
        tok_d.vic_act = act;
      end else if (!used_q || !tok_i.vic_set || (tok_i.vic_used && older)) begin
        tok_d.vic_idx  = slot_idx_i;
        tok_d.vic_used = used_q;
        tok_d.vic_last = last_q;
        tok_d.vic_act  = act;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (wr_here) begin
      used_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      group_q <= wr_i.group_id;
      addr_q  <= wr_i.node_addr;
      last_q  <= wr_i.now_ms;
    end
  end

endmodule

@@ bench/hpt_tb_pkg.sv @@
`timescale 1ns / 1ps
// bench package for the heard peer table: sighting mode codes
// shared by the checker and the bench top; no dependencies
package hpt_tb_pkg;

  typedef enum logic {
    ModeHeard     = 1'b0,
    ModeCountOnly = 1'b1
  } sight_mode_e;

endpackage

@@ bench/hpt_count_checker.sv @@
`timescale 1ns / 1ps
// checker for the heard peer table: watches the sighting, count and config ports,
// keeps its own copy of the peer table and compares every count; depends on hpt_pkg,
// hpt_if and hpt_tb_pkg
module hpt_count_checker #(
  parameter int unsigned PEER_SLOTS = hpt_pkg::PeerSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpt_sight_if        sight_mon,
  hpt_count_if        count_mon,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_count,
  output int          outstanding,
  output int          counts_checked,
  output int          replacements
);
  import hpt_tb_pkg::*;

  typedef struct {
    int         seq;
    logic [4:0] peers;
  } count_exp_t;

  count_exp_t  count_exp_q[$];
  logic [31:0] age_limit;
  bit          slot_used [PEER_SLOTS];
  logic [7:0]  slot_group[PEER_SLOTS];
  logic [7:0]  slot_addr [PEER_SLOTS];
  logic [31:0] slot_last [PEER_SLOTS];
  int          sight_seq;

  task automatic report_mismatch(input string msg);
    $display("[hpt chk] %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [4:0] predict_active(input logic mode_bit, input logic [7:0] grp,
                                                input logic [7:0] adr, input logic [31:0] now);
    int          victim;
    bit          hit;
    int          n;
    logic [31:0] age;
    victim = 0;
    hit    = 1'b0;
    n      = 0;
    if (mode_bit == ModeHeard) begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
        if (!hit) begin
          if (slot_used[i] && slot_group[i] == grp && slot_addr[i] == adr) begin
            slot_last[i] = now;
            hit = 1'b1;
          end else if (!slot_used[i]) begin
            victim = i;
          end else if (slot_used[victim] && $signed(slot_last[i] - slot_last[victim]) < 0) begin
            victim = i;
          end
        end
      end
      if (!hit) begin
        if (slot_used[victim]) replacements++;
        slot_used[victim]  = 1'b1;
        slot_group[victim] = grp;
        slot_addr[victim]  = adr;
        slot_last[victim]  = now;
      end
    end
    for (int i = 0; i < PEER_SLOTS; i++) begin
      age = now - slot_last[i];
      if (slot_used[i] && age <= age_limit) n++;
    end
    if (n > int'(hpt_pkg::CountMax)) n = int'(hpt_pkg::CountMax);
    return n[4:0];
  endfunction

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    counts_checked = 0;
    replacements   = 0;
    sight_seq      = 0;
    age_limit      = hpt_pkg::MaxAgeReset;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    count_exp_t e;
    if (!rst_ni) begin
      age_limit = hpt_pkg::MaxAgeReset;
      count_exp_q.delete();
      outstanding = 0;
      for (int i = 0; i < PEER_SLOTS; i++) begin
        slot_used[i] = 1'b0;
      end
    end else begin
      if (cfg_we_i) age_limit = cfg_wdata_i;
      if (sight_mon.valid && sight_mon.ready) begin
        e.seq   = sight_seq;
        e.peers = predict_active(sight_mon.mode, sight_mon.group_id, sight_mon.node_addr,
                                 sight_mon.now_ms);
        count_exp_q.push_back(e);
        sight_seq++;
      end
      if (count_mon.valid && count_mon.ready) begin
        if (count_exp_q.size() == 0) begin
          report_mismatch($sformatf("count %0d with no transaction waiting",
                                    count_mon.active_peers));
        end else begin
          e = count_exp_q.pop_front();
          counts_checked++;
          if (count_mon.active_peers !== e.peers) begin
            report_mismatch($sformatf("transaction %0d: active_peers %0d, predicted %0d",
                                      e.seq, count_mon.active_peers, e.peers));
          end
        end
      end
      outstanding = count_exp_q.size();
    end
  end

endmodule

@@ bench/tb_heard_peer_table_unit.sv @@
`timescale 1ns / 1ps
// bench top for heard_peer_table_unit: directed and random sightings and queries under
// several age limits, random idling on both sides; depends on hpt_pkg, hpt_if,
// hpt_tb_pkg, hpt_count_checker and the block itself
module tb_heard_peer_table_unit;
  import hpt_tb_pkg::*;

  localparam int unsigned Slots     = hpt_pkg::PeerSlotsDef;
  localparam int unsigned PoolSize  = 40;
  localparam int          PhaseN    = 7;
  localparam int          PhaseLen  = 100;
  localparam int          CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          outstanding;
  int          counts_checked;
  int          replacements;
  int          sent;
  int          cycle_count;
  bit          idle_on;
  logic [31:0] clock_ms;
  logic [15:0] key_pool[PoolSize];

  hpt_sight_if sight_ch ();
  hpt_count_if count_ch ();

  heard_peer_table_unit #(.PEER_SLOTS(Slots)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sight_i    (sight_ch),
    .count_o    (count_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  hpt_count_checker #(.PEER_SLOTS(Slots)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sight_mon     (sight_ch),
    .count_mon     (count_ch),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .counts_checked(counts_checked),
    .replacements  (replacements)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("heard_peer_table_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int stall;
    count_ch.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (count_ch.valid && count_ch.ready) stall = idle_on ? $urandom_range(0, 4) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        count_ch.ready <= 1'b0;
        stall--;
      end else begin
        count_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_sighting(input sight_mode_e m, input logic [7:0] grp,
                               input logic [7:0] adr, input logic [31:0] now);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      sight_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sight_ch.valid     <= 1'b1;
    sight_ch.mode      <= m;
    sight_ch.group_id  <= grp;
    sight_ch.node_addr <= adr;
    sight_ch.now_ms    <= now;
    do @(posedge clk_i); while (!sight_ch.ready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_counts();
    sight_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_age_limit(input logic [31:0] v);
    drain_counts();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_sighting();
    int unsigned pick;
    logic [15:0] key;
    sight_mode_e m;
    pick = $urandom_range(0, 99);
    if (pick < 60)      clock_ms += $urandom_range(0, 3000);
    else if (pick < 85) clock_ms += $urandom_range(0, 250000);
    else if (pick < 92) clock_ms = $urandom;
    else if (pick < 96) clock_ms -= $urandom_range(0, 100000);
    else                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                       : 16'($urandom);
    m = ($urandom_range(0, 4) == 0) ? ModeCountOnly : ModeHeard;
    send_sighting(m, key[15:8], key[7:0], clock_ms);
  endtask

  initial begin
    logic [31:0] limits[PhaseN];
    sight_ch.valid     = 1'b0;
    sight_ch.mode      = ModeHeard;
    sight_ch.group_id  = '0;
    sight_ch.node_addr = '0;
    sight_ch.now_ms    = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    sent               = 0;
    cycle_count        = 0;
    idle_on            = 1'b1;
    clock_ms           = '0;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    limits = '{hpt_pkg::MaxAgeReset, 32'd0, 32'hFFFF_FFFF, 32'd1, $urandom,
               $urandom_range(0, 5000), hpt_pkg::MaxAgeReset};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset, zero and all-ones age limits, empty table, key and time extremes, wrapped ages
    send_sighting(ModeCountOnly, 8'h00, 8'h00, 32'h0000_0000);
    send_sighting(ModeHeard,     8'h00, 8'h00, 32'h0000_0000);
    send_sighting(ModeHeard,     8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_sighting(ModeCountOnly, 8'h12, 8'h34, 32'h0000_0000);
    send_sighting(ModeCountOnly, 8'hFF, 8'hFF, 32'd120000);
    send_sighting(ModeCountOnly, 8'h00, 8'h00, 32'd120001);
    send_sighting(ModeHeard,     8'h00, 8'h00, 32'd1000);
    send_sighting(ModeHeard,     8'h00, 8'hFF, 32'd2000);
    send_sighting(ModeHeard,     8'hFF, 8'h00, 32'd2000);
    send_sighting(ModeHeard,     8'hA5, 8'h5A, 32'h8000_0000);
    send_sighting(ModeCountOnly, 8'h00, 8'h00, 32'd500);
    send_sighting(ModeCountOnly, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    write_age_limit(32'd0);
    send_sighting(ModeCountOnly, 8'h00, 8'h00, 32'd2000);
    send_sighting(ModeHeard,     8'h01, 8'h01, 32'd2000);
    send_sighting(ModeCountOnly, 8'h00, 8'h00, 32'd2001);
    write_age_limit(32'hFFFF_FFFF);
    send_sighting(ModeCountOnly, 8'h00, 8'h00, 32'h7FFF_FFFF);
    send_sighting(ModeHeard,     8'h5A, 8'hA5, 32'h7FFF_FFFF);
    send_sighting(ModeCountOnly, 8'hFF, 8'hFF, 32'h0000_0000);

    for (int p = 0; p < PhaseN; p++) begin
      write_age_limit(limits[p]);
      idle_on = (p != 2 && p != 5);
      for (int k = 0; k < PhaseLen; k++) begin
        if (p == 3 && k == PhaseLen / 2) drain_counts();
        random_sighting();
      end
    end

    drain_counts();
    repeat (Slots + 8) @(negedge clk_i);
    $display("covered %0d transactions and %0d counts under %0d age limit settings,", sent,
             counts_checked, PhaseN + 3);
    $display("with %0d oldest-entry replacements in a full table", replacements);
    if (fail_count == 0) begin
      $display("heard_peer_table_unit: match");
    end else begin
      $display("heard_peer_table_unit: mismatch");
    end
    $finish;
  end

endmodule
